>>> rtl/ats_pkg.sv
package ats_pkg;

	// Widths of the result word fields; wider internal counts are cut to these.
	localparam int KIND_W = 5;
	localparam int OFF_W  = 20;
	localparam int LINE_W = 16;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [OFF_W-1:0]  off_t;
	typedef logic [LINE_W-1:0] lin_t;

	typedef struct packed {
		kind_t kind;
		off_t  offset;
		off_t  length;
		lin_t  line;
		lin_t  column;
		logic  last_of_run;
	} tok_t;

	// Up to two tokens leave the front end per accepted byte.
	typedef struct packed {
		logic push0;
		logic push1;
		tok_t tok0;
		tok_t tok1;
	} push_t;

	localparam kind_t KIND_EOF        = 5'd0;
	localparam kind_t KIND_IDENT      = 5'd1;
	localparam kind_t KIND_NUMBER     = 5'd2;
	localparam kind_t KIND_PUNCT_BASE = 5'd3;
	localparam kind_t KIND_KW_BASE    = 5'd12;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = "#";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_X     = "x";

	localparam int NUM_KW = 5;
	localparam int NUM_PUNCT = 9;

	// Keywords left-aligned in six bytes, zero padded.
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		"header", {"macro", 8'h00}, {"input", 8'h00}, "opcode", "output"
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd5, 3'd5, 3'd6, 3'd6};

	localparam logic [7:0] PUNCT_CH [NUM_PUNCT] = '{
		"(", ")", "{", "}", ";", ":", "=", "*", ","
	};

	// Token queue depth; must be a power of two so the pointers wrap.
	localparam int QDEPTH = 4;

endpackage

>>> rtl/assembler_token_scanner_core.sv
// Channel  Handshake            Payload
// input    in_valid/in_ready    byte_req (one source byte, zero ends the text)
// output   out_valid/out_ready  token_kind, token_offset, token_length,
//                               token_line, token_column, last_of_run
//
// One byte is accepted per cycle while the four-word token queue has room for two.
// A byte that closes a token and is itself a mark or end of text yields two words,
// which drain one per cycle while out_ready is high; such bytes set the sustained limit.
// A word is written into the registered queue when its byte is accepted and is shown once it reaches the head.
// Reset clears the scanner to line 1, column 1, offset 0 and empties the queue.
// A stalled output only stops input once the queue holds more than two words.
module assembler_token_scanner_core #(
	parameter int OFFSET_BITS = 20,
	parameter int LINE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [19:0] token_offset,
	output logic [19:0] token_length,
	output logic [15:0] token_line,
	output logic [15:0] token_column,
	output logic        last_of_run
);

	ats_pkg::push_t push;
	ats_pkg::tok_t  head;
	logic           room;

	ats_front #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS  (LINE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.byte_req(byte_req),
		.room    (room),
		.push    (push)
	);

	ats_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (out_valid && out_ready),
		.room  (room),
		.valid (out_valid),
		.head  (head)
	);

	assign in_ready     = room;
	assign token_kind   = head.kind;
	assign token_offset = head.offset;
	assign token_length = head.length;
	assign token_line   = head.line;
	assign token_column = head.column;
	assign last_of_run  = head.last_of_run;

endmodule

>>> rtl/ats_front.sv
module ats_front #(
	parameter int OFFSET_BITS = 20,
	parameter int LINE_BITS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        byte_req,
	input  logic              room,
	output ats_pkg::push_t    push
);

	typedef enum logic [2:0] {M_IDLE, M_COMMENT, M_NUMBER, M_HEX, M_IDENT} mode_t;

	localparam logic [OFFSET_BITS-1:0] POS_MAX  = {OFFSET_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

	mode_t                  mode_q, mode_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n, start_q, start_n;
	logic [LINE_BITS-1:0]   line_q, line_n, col_q, col_n;
	logic [4:0]             cand_q, cand_n;
	logic                   lone_q, lone_n;

	logic                   fire, pending, cont, fall, has_a, has_b;
	logic [OFFSET_BITS-1:0] diff, pos_inc;
	logic [LINE_BITS-1:0]   col_inc, line_inc;
	logic [3:0]             pidx;
	ats_pkg::tok_t          tok_a, tok_b;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ats_pkg::CH_ZERO) && (c <= ats_pkg::CH_NINE);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
	endfunction

	// Returns NUM_PUNCT when the byte is not a punctuation mark.
	function automatic logic [3:0] punct_idx(input logic [7:0] c);
		logic [3:0] r;
		r = 4'(ats_pkg::NUM_PUNCT);
		for (int i = ats_pkg::NUM_PUNCT - 1; i >= 0; i--) begin
			if (c == ats_pkg::PUNCT_CH[i]) r = 4'(i);
		end
		return r;
	endfunction

	// A tab is part of an identifier; the other blanks are not.
	function automatic logic is_ident(input logic [7:0] c);
		return (c != ats_pkg::CH_NUL) && (punct_idx(c) == 4'(ats_pkg::NUM_PUNCT)) &&
			(c != ats_pkg::CH_SPACE) && (c != ats_pkg::CH_CR) &&
			(c != ats_pkg::CH_LF) && (c != ats_pkg::CH_HASH);
	endfunction

	function automatic logic [4:0] kw_filter(input logic [4:0] cand,
		input logic [OFFSET_BITS-1:0] k, input logic [7:0] c);
		logic [4:0]  r;
		logic [47:0] t;
		r = cand;
		for (int i = 0; i < ats_pkg::NUM_KW; i++) begin
			t = ats_pkg::KW_TEXT[i] << {k[2:0], 3'b000};
			if ((k >= OFFSET_BITS'(ats_pkg::KW_LEN[i])) || (t[47:40] != c)) r[i] = 1'b0;
		end
		return r;
	endfunction

	function automatic ats_pkg::kind_t kw_kind(input logic [4:0] cand,
		input logic [OFFSET_BITS-1:0] len);
		ats_pkg::kind_t r;
		r = ats_pkg::KIND_IDENT;
		for (int i = 0; i < ats_pkg::NUM_KW; i++) begin
			if (cand[i] && (len == OFFSET_BITS'(ats_pkg::KW_LEN[i])))
				r = ats_pkg::KIND_KW_BASE + ats_pkg::kind_t'(i);
		end
		return r;
	endfunction

	always_comb begin
		fire     = in_valid && room;
		pending  = (mode_q == M_NUMBER) || (mode_q == M_HEX) || (mode_q == M_IDENT);
		diff     = pos_q - start_q;
		pos_inc  = (pos_q != POS_MAX) ? pos_q + OFFSET_BITS'(1) : pos_q;
		col_inc  = (col_q != LINE_MAX) ? col_q + LINE_BITS'(1) : col_q;
		line_inc = (line_q != LINE_MAX) ? line_q + LINE_BITS'(1) : line_q;
		pidx     = punct_idx(byte_req);

		unique case (mode_q)
			M_NUMBER: cont = is_digit(byte_req) || ((byte_req == ats_pkg::CH_X) && lone_q);
			M_HEX:    cont = is_hex(byte_req);
			M_IDENT:  cont = is_ident(byte_req);
			default:  cont = 1'b0;
		endcase

		mode_n  = mode_q;
		pos_n   = pos_q;
		start_n = start_q;
		line_n  = line_q;
		col_n   = col_q;
		cand_n  = cand_q;
		lone_n  = lone_q;
		fall    = 1'b0;
		has_a   = 1'b0;
		has_b   = 1'b0;
		tok_a   = '0;
		tok_b   = '0;

		// The pending number or identifier, closed by a byte that cannot extend it.
		tok_a.kind   = (mode_q == M_IDENT) ? kw_kind(cand_q, diff) : ats_pkg::KIND_NUMBER;
		tok_a.offset = ats_pkg::off_t'(start_q);
		tok_a.length = ats_pkg::off_t'(diff);
		tok_a.line   = ats_pkg::lin_t'(line_q);
		tok_a.column = ats_pkg::lin_t'(col_q);

		if (pending) begin
			if (cont) begin
				pos_n = pos_inc;
				col_n = col_inc;
				if (mode_q == M_NUMBER) begin
					if (byte_req == ats_pkg::CH_X) mode_n = M_HEX;
					lone_n = 1'b0;
				end else if (mode_q == M_IDENT) begin
					cand_n = kw_filter(cand_q, diff, byte_req);
				end
			end else begin
				has_a  = 1'b1;
				mode_n = M_IDLE;
				fall   = 1'b1;
			end
		end else if (mode_q == M_COMMENT) begin
			if ((byte_req != ats_pkg::CH_NUL) && (byte_req != ats_pkg::CH_LF)) begin
				pos_n = pos_inc;
				col_n = col_inc;
			end else begin
				mode_n = M_IDLE;
				fall   = 1'b1;
			end
		end else begin
			fall = 1'b1;
		end

		if (fall) begin
			if (byte_req == ats_pkg::CH_NUL) begin
				has_b        = 1'b1;
				tok_b.kind   = ats_pkg::KIND_EOF;
				tok_b.offset = ats_pkg::off_t'(pos_q);
				tok_b.length = '0;
				tok_b.line   = ats_pkg::lin_t'(line_q);
				tok_b.column = ats_pkg::lin_t'(col_inc);
				mode_n       = M_IDLE;
				pos_n        = '0;
				start_n      = '0;
				line_n       = LINE_BITS'(1);
				col_n        = LINE_BITS'(1);
				cand_n       = '0;
				lone_n       = 1'b0;
			end else if ((byte_req == ats_pkg::CH_SPACE) || (byte_req == ats_pkg::CH_TAB) ||
				(byte_req == ats_pkg::CH_CR)) begin
				pos_n = pos_inc;
				col_n = col_inc;
			end else if (byte_req == ats_pkg::CH_LF) begin
				line_n = line_inc;
				col_n  = LINE_BITS'(1);
				pos_n  = pos_inc;
			end else if (byte_req == ats_pkg::CH_HASH) begin
				mode_n = M_COMMENT;
				pos_n  = pos_inc;
				col_n  = col_inc;
			end else if (is_digit(byte_req)) begin
				start_n = pos_q;
				mode_n  = M_NUMBER;
				lone_n  = (byte_req == ats_pkg::CH_ZERO);
				pos_n   = pos_inc;
				col_n   = col_inc;
			end else if (pidx != 4'(ats_pkg::NUM_PUNCT)) begin
				has_b        = 1'b1;
				tok_b.kind   = ats_pkg::KIND_PUNCT_BASE + ats_pkg::kind_t'(pidx);
				tok_b.offset = ats_pkg::off_t'(pos_q);
				tok_b.length = ats_pkg::off_t'(pos_inc - pos_q);
				tok_b.line   = ats_pkg::lin_t'(line_q);
				tok_b.column = ats_pkg::lin_t'(col_inc);
				start_n      = pos_q;
				pos_n        = pos_inc;
				col_n        = col_inc;
			end else begin
				start_n = pos_q;
				mode_n  = M_IDENT;
				cand_n  = kw_filter(5'h1F, '0, byte_req);
				pos_n   = pos_inc;
				col_n   = col_inc;
			end
		end

		tok_a.last_of_run = !has_b;
		tok_b.last_of_run = 1'b1;

		push.push0 = fire && (has_a || has_b);
		push.push1 = fire && has_a && has_b;
		push.tok0  = has_a ? tok_a : tok_b;
		push.tok1  = tok_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			line_q  <= LINE_BITS'(1);
			col_q   <= LINE_BITS'(1);
			cand_q  <= '0;
			lone_q  <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			line_q  <= line_n;
			col_q   <= col_n;
			cand_q  <= cand_n;
			lone_q  <= lone_n;
		end
	end

`ifndef SYNTHESIS
	// The end-of-text byte always leaves the scanner in its reset state.
	a_eof_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (byte_req == ats_pkg::CH_NUL)) |=>
		(mode_q == M_IDLE && pos_q == '0 && line_q == LINE_BITS'(1) && cand_q == '0))
		else $error("scanner state not cleared after end of text");

	// A token is closed only when a byte breaks it off, and such a byte always pushes it.
	a_close_on_break: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && pending && !cont) |-> (push.push0 && push.tok0.kind != ats_pkg::KIND_EOF))
		else $error("pending token not emitted on terminating byte");
`endif

endmodule

>>> rtl/ats_queue.sv
module ats_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  ats_pkg::push_t push,
	input  logic           pop,
	output logic           room,
	output logic           valid,
	output ats_pkg::tok_t  head
);

	localparam int PTR_W = $clog2(ats_pkg::QDEPTH);
	localparam int CNT_W = $clog2(ats_pkg::QDEPTH + 1);

	ats_pkg::tok_t    mem_q [ats_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Room for a full pair of tokens, judged on the registered count only.
	assign room  = (count_q <= CNT_W'(ats_pkg::QDEPTH - 2));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.push0) mem_q[wr_ptr_q] <= push.tok0;
		if (push.push1) mem_q[wr_ptr_q + PTR_W'(1)] <= push.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.push0) + PTR_W'(push.push1);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ats_pkg::QDEPTH))
		else $error("token queue count out of range");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> push.push0)
		else $error("second token written without first");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.push0 |-> room)
		else $error("token written into a full queue");
`endif

endmodule
